>>> rtl/mtca_pkg.sv
// ----------------------------------------------------------------------------
// mtca_pkg
// Shared types and constants for the mouse to camera axis block.
// ----------------------------------------------------------------------------
package mtca_pkg;

  // Input item kinds carried on in_tuser.
  typedef enum logic [1:0] {
    CMD_MOUSE = 2'd0,
    CMD_STICK = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // Configuration register indexes.
  localparam logic CFG_SENS   = 1'b0;
  localparam logic CFG_INVERT = 1'b1;

  localparam int SENS_W    = 7;
  localparam int VAL_W     = 16;
  localparam int STICK_W   = 8;
  localparam int AXX_W     = 13;
  localparam int AXY_W     = 8;
  localparam int REM_W     = 6;
  localparam int FRAC      = 40;
  localparam int HALF      = 20;
  localparam int STICK_MAX = 127;
  localparam int LANE_LAT  = 8;

  localparam logic [SENS_W-1:0] SENS_RESET = 7'd12;

  // Control from the top level to each axis lane.
  typedef struct packed {
    logic adv;
    logic add;
    logic tick;
  } lane_ctl_t;

  // Per-item information that travels beside the lanes to the merge stage.
  typedef struct packed {
    logic                       valid;
    cmd_t                       cmd;
    logic signed [STICK_W-1:0]  stick_x;
    logic signed [STICK_W-1:0]  stick_y;
  } pipe_t;

endpackage

>>> rtl/mtca_lane.sv
// ----------------------------------------------------------------------------
// mtca_lane
// One axis: saturating mouse accumulator, drain on frame tick, exact
// scaling by sensitivity*11/40 with carried fortieths, rounding and clamp.
// ----------------------------------------------------------------------------
module mtca_lane #(
  parameter int ACCUM_WIDTH = 24,
  parameter int MAX_AXIS    = 4000
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mtca_pkg::lane_ctl_t                    ctl,
  input  logic signed [mtca_pkg::VAL_W-1:0]      delta,
  input  logic [mtca_pkg::SENS_W-1:0]            sens,
  output logic signed [$clog2(MAX_AXIS+1):0]     whole
);
  import mtca_pkg::*;

  function automatic int pow2_mod5(input int n);
    int res;
    case (n & 3)
      0:       res = 1;
      1:       res = 2;
      2:       res = 4;
      default: res = 3;
    endcase
    return res;
  endfunction

  // Reduce a small digit sum modulo 5 (16 is 1 modulo 5).
  function automatic logic [2:0] fold5(input logic [7:0] s);
    logic [4:0] f;
    f = 5'(s[7:4]) + 5'(s[3:0]);
    if (f >= 5'd20) f = f - 5'd20;
    if (f >= 5'd10) f = f - 5'd10;
    if (f >= 5'd5)  f = f - 5'd5;
    return f[2:0];
  endfunction

  // Combine residues modulo 5 and modulo 8 into a residue modulo 40.
  function automatic logic [5:0] crt40(input logic [2:0] q5, input logic [2:0] r8);
    logic [5:0] res;
    logic [5:0] jj;
    logic [2:0] c5;
    res = '0;
    c5  = '0;
    for (int j = 0; j < FRAC; j++) begin
      jj = 6'(j);
      if (jj[2:0] == r8 && c5 == q5) res = jj;
      c5 = (c5 == 3'd4) ? 3'd0 : c5 + 3'd1;
    end
    return res;
  endfunction

  localparam int PW    = ACCUM_WIDTH + SENS_W + 1;
  localparam int NIB   = (PW + 3) / 4;
  localparam int PAD   = NIB * 4;
  localparam int TW    = ACCUM_WIDTH + SENS_W + 5;
  localparam int C5    = pow2_mod5(PW);
  localparam int DIVW  = $clog2(5 * MAX_AXIS + 1);
  localparam int RK    = DIVW + 3;
  localparam int WW    = $clog2(MAX_AXIS + 1) + 1;

  localparam logic [RK-1:0]             RECIP   = RK'(((1 << RK) + 4) / 5);
  localparam logic signed [TW-1:0]      SAT_POS = TW'(FRAC * MAX_AXIS);
  localparam logic signed [TW-1:0]      SAT_NEG = -SAT_POS;
  localparam logic signed [WW-1:0]      AX_POS  = WW'(MAX_AXIS);
  localparam logic signed [WW-1:0]      AX_NEG  = -AX_POS;
  localparam logic signed [ACCUM_WIDTH-1:0] ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
  localparam logic signed [ACCUM_WIDTH-1:0] ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

  // Accumulator and carry state.
  logic signed [ACCUM_WIDTH-1:0] pend_r, pend_nxt;
  logic signed [ACCUM_WIDTH:0]   psum;
  logic signed [REM_W-1:0]       rem_r, rem_nxt;

  // Pipeline stages.
  logic                          s1_tick_r, s2_tick_r, s3_tick_r, s4_tick_r;
  logic signed [ACCUM_WIDTH-1:0] s1_pend_r;
  logic signed [PW-1:0]          s2_p_r;
  logic [7:0]                    s3_sum_r;
  logic [2:0]                    s3_lo_r;
  logic                          s3_neg_r, s3_big_r;
  logic signed [1:0]             s3_psm_r;
  logic signed [TW-1:0]          s3_p11_r;
  logic [8:0]                    s4_u0_r;
  logic                          s4_neg_r, s4_big_r;
  logic signed [1:0]             s4_psm_r;
  logic signed [TW-1:0]          s4_p11_r;
  logic signed [TW-1:0]          s5_t_r;
  logic signed [REM_W-1:0]       s5_rem_r;
  logic signed [TW-1:0]          s6_d_r;
  logic                          s7_hi_r, s7_lo_r, s7_neg_r;
  logic [DIVW-1:0]               s7_b_r;
  logic signed [WW-1:0]          s8_whole_r;

  // Combinational values per stage.
  logic signed [PW-1:0]          prod;
  logic [PAD-1:0]                pu;
  logic [7:0]                    nsum;
  logic signed [TW-1:0]          pe, p11;
  logic                          psmall;
  logic [2:0]                    q5a, q5;
  logic [5:0]                    pm;
  logic [8:0]                    u0;
  logic signed [10:0]            vs;
  logic [9:0]                    vu, m10;
  logic [5:0]                    m;
  logic signed [6:0]             tsmall;
  logic                          tneg;
  logic [TW-1:0]                 ad;
  logic [DIVW+RK-1:0]            qp;
  logic [DIVW-1:0]               qf;
  logic signed [WW-1:0]          qs, whole_nxt;

  // Saturating accumulate; a frame tick drains the accumulator.
  always_comb begin
    psum = {pend_r[ACCUM_WIDTH-1], pend_r}
         + {{(ACCUM_WIDTH+1-VAL_W){delta[VAL_W-1]}}, delta};
    if (ctl.tick) begin
      pend_nxt = '0;
    end else if (ctl.add) begin
      if (psum[ACCUM_WIDTH] != psum[ACCUM_WIDTH-1]) begin
        pend_nxt = psum[ACCUM_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
        pend_nxt = psum[ACCUM_WIDTH-1:0];
      end
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_comb begin
    prod = s1_pend_r * $signed({1'b0, sens});
  end

  // Digit sum of the product for its residue modulo 5, and the product times 11.
  always_comb begin
    pu   = PAD'($unsigned(s2_p_r));
    nsum = '0;
    for (int i = 0; i < NIB; i++) begin
      nsum = nsum + 8'(pu[4*i +: 4]);
    end
    pe     = TW'(s2_p_r);
    p11    = (pe <<< 3) + (pe <<< 1) + pe;
    psmall = (s2_p_r == 0) || (s2_p_r == 1) || (s2_p_r == -1);
  end

  // Residue of the product modulo 40, then times 11.
  always_comb begin
    q5a = fold5(s3_sum_r);
    if (!s3_neg_r) begin
      q5 = q5a;
    end else if (q5a >= 3'(C5)) begin
      q5 = q5a - 3'(C5);
    end else begin
      q5 = q5a + 3'(5 - C5);
    end
    pm = crt40(q5, s3_lo_r);
    u0 = {pm, 3'b000} + {2'b00, pm, 1'b0} + {3'b000, pm};
  end

  // New carry: the scaled value modulo 40, folded into -20..20.
  always_comb begin
    vs  = $signed({2'b00, s4_u0_r}) + 11'(rem_r) + 11'sd40;
    vu  = vs[9:0];
    m10 = vu;
    for (int j = 1; j <= 12; j++) begin
      if (vu >= 10'(FRAC * j)) m10 = vu - 10'(FRAC * j);
    end
    m = m10[5:0];
    case (s4_psm_r)
      2'sb01:  tsmall = 7'(rem_r) + 7'sd11;
      2'sb11:  tsmall = 7'(rem_r) - 7'sd11;
      default: tsmall = 7'(rem_r);
    endcase
    tneg = s4_big_r ? s4_neg_r : tsmall[6];
    if (m < 6'(HALF)) begin
      rem_nxt = REM_W'(m);
    end else if (m > 6'(HALF)) begin
      rem_nxt = REM_W'(m) - REM_W'(FRAC);
    end else begin
      // Exact half rounds away from zero.
      rem_nxt = tneg ? REM_W'(HALF) : -REM_W'(HALF);
    end
  end

  // Exact quotient by 40 of the rounded value, with clamp.
  always_comb begin
    ad = s6_d_r[TW-1] ? $unsigned(-s6_d_r) : $unsigned(s6_d_r);
    qp = (DIVW+RK)'(s7_b_r) * (DIVW+RK)'(RECIP);
    qf = qp[DIVW+RK-1:RK];
    qs = WW'(qf);
    if (s7_hi_r) begin
      whole_nxt = AX_POS;
    end else if (s7_lo_r) begin
      whole_nxt = AX_NEG;
    end else begin
      whole_nxt = s7_neg_r ? -qs : qs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      rem_r     <= '0;
      s1_tick_r <= 1'b0;
      s2_tick_r <= 1'b0;
      s3_tick_r <= 1'b0;
      s4_tick_r <= 1'b0;
    end else if (ctl.adv) begin
      pend_r    <= pend_nxt;
      s1_tick_r <= ctl.tick;
      s2_tick_r <= s1_tick_r;
      s3_tick_r <= s2_tick_r;
      s4_tick_r <= s3_tick_r;
      if (s4_tick_r) rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s1_pend_r  <= pend_r;
      s2_p_r     <= prod;
      s3_sum_r   <= nsum;
      s3_lo_r    <= s2_p_r[2:0];
      s3_neg_r   <= s2_p_r[PW-1];
      s3_big_r   <= !psmall;
      s3_psm_r   <= s2_p_r[1:0];
      s3_p11_r   <= p11;
      s4_u0_r    <= u0;
      s4_neg_r   <= s3_neg_r;
      s4_big_r   <= s3_big_r;
      s4_psm_r   <= s3_psm_r;
      s4_p11_r   <= s3_p11_r;
      s5_t_r     <= s4_p11_r + TW'(rem_r);
      s5_rem_r   <= rem_nxt;
      s6_d_r     <= s5_t_r - TW'(s5_rem_r);
      s7_hi_r    <= s6_d_r > SAT_POS;
      s7_lo_r    <= s6_d_r < SAT_NEG;
      s7_neg_r   <= s6_d_r[TW-1];
      s7_b_r     <= ad[DIVW+2:3];
      s8_whole_r <= whole_nxt;
    end
  end

  assign whole = s8_whole_r;

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r >= -20) && (rem_r <= 20))
    else $error("carry left the range of half a unit");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.adv && ctl.tick |=> pend_r == '0)
    else $error("accumulator not cleared by frame tick");
`endif

endmodule

>>> rtl/mtca_merge.sv
// ----------------------------------------------------------------------------
// mtca_merge
// Combines both lanes with the stick axes, keeps the frame values and
// holds the result item in the output register.
// ----------------------------------------------------------------------------
module mtca_merge #(
  parameter int MAX_AXIS = 4000
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  mtca_pkg::pipe_t                        stage,
  input  logic signed [$clog2(MAX_AXIS+1):0]     whole_x,
  input  logic signed [$clog2(MAX_AXIS+1):0]     whole_y,
  input  logic                                   invert,
  output logic                                   out_valid,
  output logic signed [mtca_pkg::AXX_W-1:0]      axis_x,
  output logic signed [mtca_pkg::AXY_W-1:0]      axis_y
);
  import mtca_pkg::*;

  logic signed [AXX_W-1:0]   frame_x_r, frame_x_nxt;
  logic signed [AXY_W-1:0]   frame_y_r, frame_y_nxt;
  logic signed [STICK_W-1:0] stick_x_r, stick_x_nxt;
  logic signed [STICK_W-1:0] stick_y_r, stick_y_nxt;
  logic                      valid_r;
  logic signed [AXX_W-1:0]   axis_x_r, axis_x_nxt;
  logic signed [AXY_W-1:0]   axis_y_r, axis_y_nxt;
  logic signed [AXY_W-1:0]   ycl;

  always_comb begin
    if (whole_y > STICK_MAX) begin
      ycl = AXY_W'(STICK_MAX);
    end else if (whole_y < -STICK_MAX) begin
      ycl = -AXY_W'(STICK_MAX);
    end else begin
      ycl = AXY_W'(whole_y);
    end

    frame_x_nxt = frame_x_r;
    frame_y_nxt = frame_y_r;
    stick_x_nxt = stick_x_r;
    stick_y_nxt = stick_y_r;
    if (stage.valid) begin
      case (stage.cmd)
        CMD_STICK: begin
          stick_x_nxt = stage.stick_x;
          stick_y_nxt = stage.stick_y;
        end
        CMD_TICK: begin
          frame_x_nxt = AXX_W'(whole_x);
          frame_y_nxt = invert ? ycl : -ycl;
        end
        default: begin
        end
      endcase
    end

    // A nonzero stick deflection wins over the mouse on its axis.
    axis_x_nxt = (stick_x_nxt != 0) ? AXX_W'(stick_x_nxt) : frame_x_nxt;
    axis_y_nxt = (stick_y_nxt != 0) ? stick_y_nxt : frame_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_x_r <= '0;
      frame_y_r <= '0;
      stick_x_r <= '0;
      stick_y_r <= '0;
      valid_r   <= 1'b0;
    end else if (adv) begin
      frame_x_r <= frame_x_nxt;
      frame_y_r <= frame_y_nxt;
      stick_x_r <= stick_x_nxt;
      stick_y_r <= stick_y_nxt;
      valid_r   <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && stage.valid) begin
      axis_x_r <= axis_x_nxt;
      axis_y_r <= axis_y_nxt;
    end
  end

  assign out_valid = valid_r;
  assign axis_x    = axis_x_r;
  assign axis_y    = axis_y_r;

endmodule

>>> rtl/mouse_to_camera_axis.sv
// ----------------------------------------------------------------------------
// mouse_to_camera_axis
// Mouse motion and stick deflection to two camera axis values.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless the result side stalls, and
// returns one result item for every item, in order. Each axis has its own
// lane: an eight-stage pipeline that accumulates mouse counts and, on a frame
// tick, scales the drained count by sensitivity*11/40 with an exact carry in
// fortieths; a merge stage then applies the stick override and fills the
// output register. The carry is closed in a single lane stage, so frame
// ticks may follow one another in consecutive cycles. When the result side
// stalls, the whole pipeline holds and in_tready falls. There is no clearing
// pass after reset. Configuration must be written while no item is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module mouse_to_camera_axis #(
  parameter int ACCUM_WIDTH = 24,
  parameter int MAX_AXIS    = 4000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value_x [15:0], value_y [31:16]
  input  logic [1:0]  in_tuser,   // command [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // axis_x [12:0], axis_y [20:13], zero [23:21]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata
);
  import mtca_pkg::*;

  localparam int WW = $clog2(MAX_AXIS + 1) + 1;

  function automatic logic signed [STICK_W-1:0] clamp_stick(
    input logic signed [VAL_W-1:0] v
  );
    logic signed [STICK_W-1:0] res;
    if (v > STICK_MAX) begin
      res = STICK_W'(STICK_MAX);
    end else if (v < -STICK_MAX) begin
      res = -STICK_W'(STICK_MAX);
    end else begin
      res = STICK_W'(v);
    end
    return res;
  endfunction

  logic [SENS_W-1:0]        sens_r;
  logic                     invert_r;
  logic                     adv;
  logic                     accept;
  cmd_t                     cmd;
  logic signed [VAL_W-1:0]  value_x, value_y;
  lane_ctl_t                ctl;
  pipe_t                    pipe_r [LANE_LAT];
  pipe_t                    pipe_nxt;
  logic signed [WW-1:0]     whole_x, whole_y;
  logic signed [AXX_W-1:0]  axis_x;
  logic signed [AXY_W-1:0]  axis_y;

  assign cmd     = cmd_t'(in_tuser);
  assign value_x = in_tdata[15:0];
  assign value_y = in_tdata[31:16];

  // Everything moves together unless the output register is full and held.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;

  always_comb begin
    ctl.adv  = adv;
    ctl.add  = accept && (cmd == CMD_MOUSE);
    ctl.tick = accept && (cmd == CMD_TICK);

    pipe_nxt.valid   = accept;
    pipe_nxt.cmd     = cmd;
    pipe_nxt.stick_x = clamp_stick(value_x);
    pipe_nxt.stick_y = clamp_stick(value_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r   <= SENS_RESET;
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SENS:   sens_r   <= cfg_wdata;
        CFG_INVERT: invert_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) pipe_r[i] <= '0;
    end else if (adv) begin
      pipe_r[0] <= pipe_nxt;
      for (int i = 1; i < LANE_LAT; i++) pipe_r[i] <= pipe_r[i-1];
    end
  end

  mtca_lane #(
    .ACCUM_WIDTH (ACCUM_WIDTH),
    .MAX_AXIS    (MAX_AXIS)
  ) u_lane_x (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .delta (value_x),
    .sens  (sens_r),
    .whole (whole_x)
  );

  mtca_lane #(
    .ACCUM_WIDTH (ACCUM_WIDTH),
    .MAX_AXIS    (MAX_AXIS)
  ) u_lane_y (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .delta (value_y),
    .sens  (sens_r),
    .whole (whole_y)
  );

  mtca_merge #(
    .MAX_AXIS (MAX_AXIS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .stage     (pipe_r[LANE_LAT-1]),
    .whole_x   (whole_x),
    .whole_y   (whole_y),
    .invert    (invert_r),
    .out_valid (out_tvalid),
    .axis_x    (axis_x),
    .axis_y    (axis_y)
  );

  assign out_tdata = {3'b000, axis_y, axis_x};

`ifndef SYNTHESIS
  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(pipe_r[LANE_LAT-1].valid))
    else $error("result item without an item at the end of the pipeline");

  a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(pipe_r[0]) && $stable(pipe_r[LANE_LAT-1]))
    else $error("pipeline moved while the output was held");
`endif

endmodule
